// ===== src/kaep_pkg.sv =====
// ----------------------------------------------------------------------------
// kaep_pkg
// Shared constants, types and codes of the keypad address entry parser.
// ----------------------------------------------------------------------------
package kaep_pkg;

   localparam int BUFFER_DEPTH = 19;
   localparam int MAX_FIELDS   = 5;

   localparam int KEY_W     = 8;
   localparam int BYTE_W    = 8;
   localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
   localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
   localparam int FIELD_W   = $clog2(MAX_FIELDS + 1);
   localparam int MAX_RUN   = 3;
   localparam int RUN_W     = 2;
   localparam int VAL_W     = 15;
   localparam int BYTE_MAX  = 255;
   localparam int OUT_BYTES = 5;
   localparam int LEN_W     = 5;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 3;
   localparam int RSP_W     = ((LEN_W + OUT_BYTES * BYTE_W + 7) / 8) * 8;
   localparam int RSP_PAD_W = RSP_W - LEN_W - OUT_BYTES * BYTE_W;

   typedef enum logic [STAT_W-1:0] {
      STAT_HANDLED = 2'd0,
      STAT_PARSED  = 2'd1,
      STAT_ERROR   = 2'd2,
      STAT_IGNORED = 2'd3
   } kaep_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } kaep_state_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KEY_ENABLED = 3'd0,
      REG_SEPARATOR   = 3'd1,
      REG_CONFIRM     = 3'd2,
      REG_ERASE       = 3'd3,
      REG_ESCAPE      = 3'd4
   } kaep_reg_type;

   // one buffered key on its way from the key store to the field parser
   typedef struct packed {
      logic             start;
      logic             vld;
      logic             last;
      logic [KEY_W-1:0] key;
   } kaep_scan_type;

endpackage

// ===== src/kaep_key_store.sv =====
// ----------------------------------------------------------------------------
// kaep_key_store
// Edit buffer memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kaep_key_store (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [kaep_pkg::ADDR_W-1:0] wr_addr,
   input  logic [kaep_pkg::KEY_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [kaep_pkg::ADDR_W-1:0] rd_addr,
   output logic [kaep_pkg::KEY_W-1:0]  rd_data
);

   logic [kaep_pkg::KEY_W-1:0] mem [kaep_pkg::BUFFER_DEPTH];
   logic [kaep_pkg::KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/kaep_parser.sv =====
// ----------------------------------------------------------------------------
// kaep_parser
// Field accumulator: folds scanned keys into decimal fields and holds the
// address bytes.
// ----------------------------------------------------------------------------
module kaep_parser (
   input  logic                                            clock,
   input  logic                                            reset,
   input  kaep_pkg::kaep_scan_type                         scan,
   input  logic [kaep_pkg::KEY_W-1:0]                      separator_code,
   output logic                                            error,
   output logic [kaep_pkg::OUT_BYTES-1:0][kaep_pkg::BYTE_W-1:0] addr_bytes
);

   logic [kaep_pkg::RUN_W-1:0]   run_ff,   run_in;
   logic [kaep_pkg::VAL_W-1:0]   val_ff,   val_in;
   logic [kaep_pkg::FIELD_W-1:0] field_ff, field_in;
   logic                         err_ff,   err_in;
   logic                         byte_wr;
   logic                         is_sep;
   logic [kaep_pkg::BYTE_W-1:0]  addr_ff [kaep_pkg::MAX_FIELDS];

   always_comb begin
      run_in   = run_ff;
      val_in   = val_ff;
      field_in = field_ff;
      err_in   = err_ff;
      byte_wr  = 1'b0;
      is_sep   = scan.last || (scan.key == separator_code);
      if (scan.start) begin
         run_in   = '0;
         val_in   = '0;
         field_in = '0;
         err_in   = 1'b0;
      end else if (scan.vld && !err_ff) begin
         if (!is_sep) begin
            if (run_ff == kaep_pkg::RUN_W'(kaep_pkg::MAX_RUN)) begin
               err_in = 1'b1;
            end else begin
               run_in = run_ff + 1'b1;
               // value * 10 as two shifts
               val_in = kaep_pkg::VAL_W'({val_ff, 3'b000}) +
                        kaep_pkg::VAL_W'({val_ff, 1'b0}) +
                        kaep_pkg::VAL_W'(scan.key);
            end
         end else if ((field_ff >= kaep_pkg::FIELD_W'(kaep_pkg::MAX_FIELDS)) ||
                      (val_ff > kaep_pkg::VAL_W'(kaep_pkg::BYTE_MAX))) begin
            err_in = 1'b1;
         end else begin
            byte_wr  = 1'b1;
            field_in = field_ff + 1'b1;
            run_in   = '0;
            val_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= '0;
         val_ff   <= '0;
         field_ff <= '0;
         err_ff   <= 1'b0;
      end else begin
         run_ff   <= run_in;
         val_ff   <= val_in;
         field_ff <= field_in;
         err_ff   <= err_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < kaep_pkg::MAX_FIELDS; i++) begin
         if (reset) begin
            addr_ff[i] <= '0;
         end else if (byte_wr && (field_ff == kaep_pkg::FIELD_W'(i))) begin
            addr_ff[i] <= val_ff[kaep_pkg::BYTE_W-1:0];
         end
      end
   end

   for (genvar j = 0; j < kaep_pkg::OUT_BYTES; j++) begin : g_out
      if (j < kaep_pkg::MAX_FIELDS) begin : g_held
         assign addr_bytes[j] = addr_ff[j];
      end else begin : g_none
         assign addr_bytes[j] = '0;
      end
   end

   assign error = err_ff;

endmodule

// ===== src/keypad_address_entry_parser.sv =====
// ----------------------------------------------------------------------------
// keypad_address_entry_parser
// Keypad edit buffer with erase, escape and confirm; confirm parses the
// buffer into dotted decimal address bytes.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tdata[7:0]  key_code
//  rsp      out        rsp_tvalid/tready    tuser status, tdata length + bytes
//  csr      in         csr_valid/ready      csr_index, csr_data
//
//  Ordinary keys: a request is decoded in EXEC and its result registered;
//  no new request is taken until the block is back in IDLE. Confirm walks the
//  buffer one key per cycle from the key store's read port in SCAN, then
//  passes DRAIN and loads the result in DONE.
//  Reset empties the buffer and clears the address bytes; no clearing pass.
//  A stalled result holds a request in its decode step, or a parse in its
//  final step; req_tready stays low until the result slot frees.
// ----------------------------------------------------------------------------
module keypad_address_entry_parser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [7:0] key_code
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [kaep_pkg::STAT_W-1:0]       rsp_tuser,   // [1:0] status
   // [4:0] entry_length, [12:5] addr_byte0, [20:13] addr_byte1,
   // [28:21] addr_byte2, [36:29] addr_byte3, [44:37] addr_byte4, rest zero
   output logic [kaep_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [kaep_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                        csr_data
);

   kaep_pkg::kaep_state_type     state_ff, state_in;
   logic [kaep_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [kaep_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [kaep_pkg::CNT_W-1:0]   scan_pos_ff, scan_pos_in;
   logic                         pipe_vld_ff, pipe_vld_in;
   logic                         pipe_last_ff, pipe_last_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [kaep_pkg::STAT_W-1:0]  rsp_user_ff;
   logic [kaep_pkg::RSP_W-1:0]   rsp_data_ff;

   logic                         enabled_ff;
   logic [kaep_pkg::KEY_W-1:0]   sep_ff, confirm_ff, erase_ff, escape_ff;

   logic                         slot_free;
   logic                         load;
   kaep_pkg::kaep_status_type    status;
   logic                         wr_en;
   logic                         rd_en;
   logic                         scan_start;
   logic [kaep_pkg::KEY_W-1:0]   rd_data;
   logic                         parse_err;
   logic [kaep_pkg::OUT_BYTES-1:0][kaep_pkg::BYTE_W-1:0] addr_bytes;
   kaep_pkg::kaep_scan_type      scan;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         sep_ff     <= 8'd10;
         confirm_ff <= 8'd11;
         erase_ff   <= 8'd12;
         escape_ff  <= 8'd13;
      end else if (csr_valid) begin
         unique case (csr_index)
            kaep_pkg::REG_KEY_ENABLED: enabled_ff <= csr_data[0];
            kaep_pkg::REG_SEPARATOR:   sep_ff     <= csr_data;
            kaep_pkg::REG_CONFIRM:     confirm_ff <= csr_data;
            kaep_pkg::REG_ERASE:       erase_ff   <= csr_data;
            kaep_pkg::REG_ESCAPE:      escape_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      count_in     = count_ff;
      scan_pos_in  = scan_pos_ff;
      pipe_vld_in  = 1'b0;
      pipe_last_in = 1'b0;
      req_tready   = 1'b0;
      load         = 1'b0;
      status       = kaep_pkg::STAT_HANDLED;
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      scan_start   = 1'b0;
      unique case (state_ff)
         kaep_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               key_in   = req_tdata;
               state_in = kaep_pkg::ST_EXEC;
            end
         end
         kaep_pkg::ST_EXEC: begin
            if (enabled_ff && (key_ff != escape_ff) && (key_ff == confirm_ff) &&
                (count_ff != '0)) begin
               scan_start  = 1'b1;
               scan_pos_in = '0;
               state_in    = kaep_pkg::ST_SCAN;
            end else if (slot_free) begin
               load     = 1'b1;
               state_in = kaep_pkg::ST_IDLE;
               if (!enabled_ff) begin
                  status = kaep_pkg::STAT_IGNORED;
               end else if (key_ff == escape_ff) begin
                  status = kaep_pkg::STAT_HANDLED;
               end else if (key_ff == confirm_ff) begin
                  count_in = '0;
               end else if (key_ff == erase_ff) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end else if (count_ff < kaep_pkg::CNT_W'(kaep_pkg::BUFFER_DEPTH)) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
         end
         kaep_pkg::ST_SCAN: begin
            // the trailing separator goes out as a last marker with no read
            rd_en        = (scan_pos_ff != count_ff);
            pipe_vld_in  = 1'b1;
            pipe_last_in = (scan_pos_ff == count_ff);
            scan_pos_in  = scan_pos_ff + 1'b1;
            if (scan_pos_ff == count_ff) begin
               state_in = kaep_pkg::ST_DRAIN;
            end
         end
         kaep_pkg::ST_DRAIN: begin
            state_in = kaep_pkg::ST_DONE;
         end
         kaep_pkg::ST_DONE: begin
            if (slot_free) begin
               load     = 1'b1;
               status   = parse_err ? kaep_pkg::STAT_ERROR : kaep_pkg::STAT_PARSED;
               count_in = '0;
               state_in = kaep_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = kaep_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kaep_pkg::ST_IDLE;
         count_ff     <= '0;
         scan_pos_ff  <= '0;
         pipe_vld_ff  <= 1'b0;
         pipe_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         scan_pos_ff  <= scan_pos_in;
         pipe_vld_ff  <= pipe_vld_in;
         pipe_last_ff <= pipe_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (load) begin
         rsp_user_ff <= status;
         rsp_data_ff <= {{kaep_pkg::RSP_PAD_W{1'b0}}, addr_bytes,
                         kaep_pkg::LEN_W'(count_in)};
      end
   end

   kaep_key_store u_key_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[kaep_pkg::ADDR_W-1:0]),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (scan_pos_ff[kaep_pkg::ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign scan.start = scan_start;
   assign scan.vld   = pipe_vld_ff;
   assign scan.last  = pipe_last_ff;
   assign scan.key   = rd_data;

   kaep_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .scan           (scan),
      .separator_code (sep_ff),
      .error          (parse_err),
      .addr_bytes     (addr_bytes)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tdata  = rsp_data_ff;

   // buffer never overfills
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kaep_pkg::CNT_W'(kaep_pkg::BUFFER_DEPTH))
      else $error("entry count beyond buffer depth");

   // scan pointer never passes the entry count
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == kaep_pkg::ST_SCAN) |-> (scan_pos_ff <= count_ff))
      else $error("scan pointer beyond entry count");

   // an accepted request is worked on in the next cycle
   a_req_exec: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == kaep_pkg::ST_EXEC))
      else $error("request not decoded after acceptance");

   // a new result comes only from the decode or the end of a parse
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid && !rsp_tready)) |->
      ($past(state_ff) == kaep_pkg::ST_EXEC || $past(state_ff) == kaep_pkg::ST_DONE))
      else $error("result loaded from an unexpected state");

   // the key store is never read and written in the same cycle
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> !wr_en)
      else $error("key store read and written in the same cycle");

endmodule
